[rtl/core/pcne_pkg.sv]
// Shared constants, payload types and configuration codes for the neighbor enumerator.
package pcne_pkg;

  localparam int DIM            = 3;
  localparam int COORD_BITS     = 8;
  localparam int NEIGHBOR_COUNT = 27;
  localparam int POS_BITS       = 24;

  localparam int FIELD_W   = 24;
  localparam int SIDE_W    = 24;
  localparam int CNT_W     = 9;
  localparam int IDX_W     = 24;
  localparam int NUM_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;

  localparam int P_W      = (POS_BITS < FIELD_W) ? POS_BITS : FIELD_W;
  localparam int DIV_W    = SIDE_W + COORD_BITS;
  localparam int EFF_W    = (COORD_BITS + 1 > CNT_W) ? COORD_BITS + 1 : CNT_W;
  localparam int K_W      = $clog2(NEIGHBOR_COUNT);
  localparam int PK_W     = (DIM * COORD_BITS > IDX_W) ? DIM * COORD_BITS : IDX_W;
  localparam int N_STAGES = COORD_BITS + 2;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(256);
  localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE_X,
    CFG_SIDE_Y,
    CFG_SIDE_Z,
    CFG_COUNT_X,
    CFG_COUNT_Y,
    CFG_COUNT_Z
  } cfg_reg_e;

  typedef struct packed {
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] neighbor_index;
    logic [NUM_W-1:0] neighbor_number;
    logic             out_of_range;
    logic             last;
  } out_item_t;

  typedef logic [DIM-1:0][SIDE_W-1:0] side_arr_t;
  typedef logic [DIM-1:0][CNT_W-1:0]  cnt_arr_t;

  // One stage of the cell-coordinate divider: partial remainder, quotient bits
  // so far, and the quotient reduced modulo the effective cell count.
  typedef struct packed {
    logic                                 bad;
    logic [DIM-1:0][P_W-1:0]              rem;
    logic [DIM-1:0][COORD_BITS-1:0]       quo;
    logic [DIM-1:0][EFF_W-1:0]            md;
  } div_stage_t;

  typedef struct packed {
    logic                           bad;
    logic [DIM-1:0][COORD_BITS-1:0] home;
    logic [DIM-1:0][COORD_BITS-1:0] plus;
    logic [DIM-1:0][COORD_BITS-1:0] minus;
  } cell_t;

endpackage

[rtl/core/pcne_cellpipe.sv]
// Pipelined cell-coordinate divider with range check and periodic neighbor coordinates.
module pcne_cellpipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pcne_pkg::in_item_t in_data_i,
  input  pcne_pkg::side_arr_t side_i,
  input  pcne_pkg::cnt_arr_t  count_i,
  output logic               cell_valid_o,
  input  logic               cell_take_i,
  output pcne_pkg::cell_t    cell_o
);
  import pcne_pkg::*;

  div_stage_t                st_q  [N_STAGES];
  div_stage_t                nxt   [N_STAGES];
  logic [N_STAGES-1:0]       vld_q;
  logic [N_STAGES-1:0]       src_v;
  logic [N_STAGES:0]         rdy;
  cell_t                     cell_q;
  cell_t                     cell_d;
  logic                      cell_vld_q;
  logic [DIM-1:0][EFF_W-1:0] eff;
  logic [2:0][FIELD_W-1:0]   pos_all;
  div_stage_t                entry;

  // Range check: the quotient fits COORD_BITS bits only if pos < side * 2^COORD_BITS.
  function automatic div_stage_t range_check(div_stage_t st, side_arr_t side);
    div_stage_t r;
    r = st;
    r.bad = 1'b0;
    for (int i = 0; i < DIM; i++) begin
      if (DIV_W'(st.rem[i]) >= {side[i], COORD_BITS'(0)}) r.bad = 1'b1;
    end
    return r;
  endfunction

  // One restoring-division bit per axis, plus the matching step of q mod count.
  function automatic div_stage_t div_step(div_stage_t st, side_arr_t side,
                                          logic [DIM-1:0][EFF_W-1:0] ef, int j);
    div_stage_t       r;
    logic [DIV_W-1:0] trial;
    logic             ge;
    logic [EFF_W:0]   md2;
    r = st;
    for (int i = 0; i < DIM; i++) begin
      trial = DIV_W'(side[i]) << j;
      ge = DIV_W'(st.rem[i]) >= trial;
      if (ge) r.rem[i] = P_W'(DIV_W'(st.rem[i]) - trial);
      r.quo[i][j] = ge;
      md2 = {st.md[i], ge};
      if (md2 >= (EFF_W + 1)'(ef[i])) r.md[i] = EFF_W'(md2 - (EFF_W + 1)'(ef[i]));
      else r.md[i] = EFF_W'(md2);
    end
    return r;
  endfunction

  assign pos_all = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};

  always_comb begin
    entry = '0;
    for (int i = 0; i < DIM; i++) begin
      entry.rem[i] = pos_all[i][P_W-1:0];
      eff[i] = (count_i[i] == '0) ? EFF_W'(1 << COORD_BITS) : EFF_W'(count_i[i]);
    end
  end

  always_comb begin
    for (int s = 0; s < N_STAGES; s++) begin
      if (s == 0) nxt[s] = entry;
      else if (s == 1) nxt[s] = range_check(st_q[0], side_i);
      else nxt[s] = div_step(st_q[s-1], side_i, eff, COORD_BITS + 1 - s);
    end
  end

  // Stage ready chain: a stage takes when empty or when its successor takes.
  always_comb begin
    rdy[N_STAGES] = !cell_vld_q || cell_take_i;
    for (int s = N_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
    for (int s = 0; s < N_STAGES; s++) begin
      src_v[s] = (s == 0) ? in_valid_i : vld_q[(s == 0) ? 0 : s - 1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      cell_vld_q <= 1'b0;
    end else begin
      for (int s = 0; s < N_STAGES; s++) begin
        if (rdy[s]) vld_q[s] <= src_v[s];
      end
      if (rdy[N_STAGES]) cell_vld_q <= vld_q[N_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < N_STAGES; s++) begin
      if (rdy[s] && src_v[s]) st_q[s] <= nxt[s];
    end
    if (rdy[N_STAGES] && vld_q[N_STAGES-1]) cell_q <= cell_d;
  end

  // Neighbor coordinates: +1 reduces modulo the count, -1 wraps only at zero.
  always_comb begin
    logic [EFF_W-1:0] m1;
    logic [EFF_W-1:0] top;
    cell_d.bad = st_q[N_STAGES-1].bad;
    for (int i = 0; i < DIM; i++) begin
      m1  = EFF_W'(st_q[N_STAGES-1].md[i] + EFF_W'(1));
      top = EFF_W'(eff[i] - EFF_W'(1));
      cell_d.home[i]  = st_q[N_STAGES-1].quo[i];
      cell_d.plus[i]  = (m1 == eff[i]) ? '0 : m1[COORD_BITS-1:0];
      cell_d.minus[i] = (st_q[N_STAGES-1].quo[i] == '0) ? top[COORD_BITS-1:0]
                                                        : st_q[N_STAGES-1].quo[i] - 1'b1;
    end
  end

  assign cell_valid_o = cell_vld_q;
  assign cell_o       = cell_q;

endmodule

[rtl/core/pcne_enum.sv]
// Walks the neighbor offsets of one cell and drives the registered result item.
module pcne_enum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cell_valid_i,
  output logic                cell_take_o,
  input  pcne_pkg::cell_t     cell_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcne_pkg::out_item_t out_data_o
);
  import pcne_pkg::*;

  logic                   busy_q;
  cell_t                  cur_q;
  logic [K_W-1:0]         k_q;
  logic [DIM-1:0][1:0]    dig_q;
  logic [DIM-1:0][1:0]    dig_d;
  logic                   emit;
  logic                   last_now;
  logic                   load;
  logic                   out_valid_q;
  out_item_t              out_q;
  out_item_t              res;
  logic [DIM*COORD_BITS-1:0] packed_c;
  logic [PK_W-1:0]        packed_w;

  assign emit        = busy_q && (!out_valid_q || !out_stall_i);
  assign last_now    = cur_q.bad || (k_q == K_W'(NEIGHBOR_COUNT - 1));
  assign cell_take_o = !busy_q || (emit && last_now);
  assign load        = cell_take_o && cell_valid_i;

  // Base-3 increment of the offset digits, axis 0 lowest.
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < DIM; i++) begin
      if (!carry) dig_d[i] = dig_q[i];
      else if (dig_q[i] == 2'd2) dig_d[i] = 2'd0;
      else begin
        dig_d[i] = dig_q[i] + 2'd1;
        carry = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      case (dig_q[i])
        2'd1:    packed_c[(DIM-1-i)*COORD_BITS +: COORD_BITS] = cur_q.plus[i];
        2'd2:    packed_c[(DIM-1-i)*COORD_BITS +: COORD_BITS] = cur_q.minus[i];
        default: packed_c[(DIM-1-i)*COORD_BITS +: COORD_BITS] = cur_q.home[i];
      endcase
    end
    packed_w = PK_W'(packed_c);
    if (cur_q.bad) begin
      res.neighbor_index  = '0;
      res.neighbor_number = '0;
      res.out_of_range    = 1'b1;
      res.last            = 1'b1;
    end else begin
      res.neighbor_index  = packed_w[IDX_W-1:0];
      res.neighbor_number = NUM_W'(k_q);
      res.out_of_range    = 1'b0;
      res.last            = last_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      dig_q       <= '0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        k_q    <= '0;
        dig_q  <= '0;
      end else if (emit && last_now) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        k_q   <= k_q + 1'b1;
        dig_q <= dig_d;
      end
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= cell_i;
    if (emit) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/periodic_cell_neighbor_enumerator.sv]
// Top level of the periodic cell-list neighbor enumerator: registers, pipeline, enumerator.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (pos_x, pos_y, pos_z)
//   out      output     out_valid_o / out_stall_i out_data_o (index, number, range, last)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// An accepted item passes the entry, range-check and divider stages, the cell register, the
// enumerator's cell and output registers before its first result; the divider yields one
// quotient bit per stage and takes an item every cycle unless stalled. Each in-range item
// gives NEIGHBOR_COUNT (27) results, one per cycle unless stalled; a flagged item gives one.
// Reset clears all valid bits and loads side 256 and count 256 on every axis.
// A stall on the output holds the result register and backs up the pipeline stage by stage.
module periodic_cell_neighbor_enumerator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pcne_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pcne_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pcne_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcne_pkg::CFG_W-1:0]      cfg_data_i
);
  import pcne_pkg::*;

  logic [2:0][SIDE_W-1:0] side_q;
  logic [2:0][CNT_W-1:0]  count_q;
  side_arr_t              side_arr;
  cnt_arr_t               cnt_arr;
  logic                   cell_valid;
  logic                   cell_take;
  cell_t                  cell_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q  <= {3{SIDE_RESET}};
      count_q <= {3{CNT_RESET}};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_SIDE_X:  side_q[0]  <= cfg_data_i[SIDE_W-1:0];
        CFG_SIDE_Y:  side_q[1]  <= cfg_data_i[SIDE_W-1:0];
        CFG_SIDE_Z:  side_q[2]  <= cfg_data_i[SIDE_W-1:0];
        CFG_COUNT_X: count_q[0] <= cfg_data_i[CNT_W-1:0];
        CFG_COUNT_Y: count_q[1] <= cfg_data_i[CNT_W-1:0];
        CFG_COUNT_Z: count_q[2] <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign side_arr = side_q[DIM-1:0];
  assign cnt_arr  = count_q[DIM-1:0];

  pcne_cellpipe u_cellpipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .side_i       (side_arr),
    .count_i      (cnt_arr),
    .cell_valid_o (cell_valid),
    .cell_take_i  (cell_take),
    .cell_o       (cell_item)
  );

  pcne_enum u_enum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_valid_i (cell_valid),
    .cell_take_o  (cell_take),
    .cell_i       (cell_item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTHESIS
  a_flag_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_of_range) |->
      (out_data_o.last && out_data_o.neighbor_number == '0 && out_data_o.neighbor_index == '0))
    else $error("flagged result is not a lone final result");

  a_number_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.neighbor_number <= NUM_W'(NEIGHBOR_COUNT - 1)))
    else $error("neighbor number beyond the offset count");

  a_walk_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last) |=>
      (out_valid_o && out_data_o.neighbor_number ==
        NUM_W'($past(out_data_o.neighbor_number) + 1'b1)))
    else $error("neighbor walk skipped or stalled an offset");

  a_last_is_final_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last && !out_data_o.out_of_range) |->
      (out_data_o.neighbor_number == NUM_W'(NEIGHBOR_COUNT - 1)))
    else $error("last flag on an offset other than the final one");
`endif

endmodule

[test/periodic_cell_neighbor_enumerator_tb.sv]
// Self-checking testbench for the periodic cell-list neighbor enumerator.
module periodic_cell_neighbor_enumerator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcne_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = COORD_BITS + 6;
  localparam int HOLD_LONG   = 400;
  localparam int MAX_REPORTS = 10;

  localparam longint unsigned COORD_MAX = (64'd1 << COORD_BITS) - 1;
  localparam logic [FIELD_W-1:0] POS_MAX  = {FIELD_W{1'b1}};
  localparam logic [SIDE_W-1:0]  SIDE_MAX = {SIDE_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX  = {CNT_W{1'b1}};

  // Base-3 offset digit per axis
  localparam int STEP_STAY = 0;
  localparam int STEP_UP   = 1;
  localparam int STEP_DOWN = 2;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  periodic_cell_neighbor_enumerator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Local copy of the register file
  logic [SIDE_W-1:0] side_cfg  [DIM];
  logic [CNT_W-1:0]  count_cfg [DIM];

  out_item_t neighbor_q[$];

  bit src_gaps;
  bit sink_gaps;
  int hold_req;
  int errors;
  int cycles;
  int positions_sent;
  int flagged_sent;
  int results_seen;
  int settings_used;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycles, neighbor_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // Result-side stall: long hold-off on request, otherwise random bursts
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        out_stall_i <= 1'b1;
        hold_req--;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 10)) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (neighbor_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected result: idx=%06h num=%0d oor=%0b last=%0b", $realtime,
                   out_data_o.neighbor_index, out_data_o.neighbor_number,
                   out_data_o.out_of_range, out_data_o.last);
      end else begin
        want = neighbor_q.pop_front();
        if (out_data_o !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch: exp idx=%06h num=%0d oor=%0b last=%0b | got idx=%06h num=%0d oor=%0b last=%0b",
                     $realtime, want.neighbor_index, want.neighbor_number,
                     want.out_of_range, want.last, out_data_o.neighbor_index,
                     out_data_o.neighbor_number, out_data_o.out_of_range, out_data_o.last);
        end
      end
    end
  end

  // Work out the results one position causes under the current registers
  task automatic expect_neighbors(input in_item_t item);
    logic [FIELD_W-1:0] p [DIM];
    longint unsigned    home [DIM];
    longint unsigned    quo, span, moved, packed_idx;
    int                 code;
    bit                 flagged;
    out_item_t          r;
    p[0] = item.pos_x;
    p[1] = item.pos_y;
    p[2] = item.pos_z;
    flagged = 1'b0;
    for (int a = 0; a < DIM; a++) begin
      quo = (side_cfg[a] == 0) ? COORD_MAX + 1 : p[a] / side_cfg[a];
      if (quo > COORD_MAX) flagged = 1'b1;
      home[a] = quo & COORD_MAX;
    end
    if (flagged) begin
      r.neighbor_index  = '0;
      r.neighbor_number = '0;
      r.out_of_range    = 1'b1;
      r.last            = 1'b1;
      neighbor_q.push_back(r);
      flagged_sent++;
      return;
    end
    for (int k = 0; k < NEIGHBOR_COUNT; k++) begin
      code = k;
      packed_idx = 0;
      for (int a = 0; a < DIM; a++) begin
        span = (count_cfg[a] == 0) ? COORD_MAX + 1 : count_cfg[a];
        case (code % 3)
          STEP_UP:   moved = (home[a] + 1) % span;
          STEP_DOWN: moved = (home[a] == 0) ? span - 1 : home[a] - 1;
          default:   moved = home[a];
        endcase
        // axis 0 ends up in the most significant bits
        packed_idx = (packed_idx << COORD_BITS) | (moved & COORD_MAX);
        code = code / 3;
      end
      r.neighbor_index  = packed_idx[IDX_W-1:0];
      r.neighbor_number = NUM_W'(k);
      r.out_of_range    = 1'b0;
      r.last            = (k == NEIGHBOR_COUNT - 1);
      neighbor_q.push_back(r);
    end
  endtask

  task automatic send_position(input logic [FIELD_W-1:0] px, py, pz);
    in_item_t item;
    item.pos_x = px;
    item.pos_y = py;
    item.pos_z = pz;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expect_neighbors(item);
    positions_sent++;
  endtask

  // Drop valid and hold until every expected result is back
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (neighbor_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (sel)
      CFG_SIDE_X:  side_cfg[0]  = val[SIDE_W-1:0];
      CFG_SIDE_Y:  side_cfg[1]  = val[SIDE_W-1:0];
      CFG_SIDE_Z:  side_cfg[2]  = val[SIDE_W-1:0];
      CFG_COUNT_X: count_cfg[0] = val[CNT_W-1:0];
      CFG_COUNT_Y: count_cfg[1] = val[CNT_W-1:0];
      CFG_COUNT_Z: count_cfg[2] = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Only called with the block drained
  task automatic load_config(input logic [SIDE_W-1:0] sx, sy, sz,
                             input logic [CNT_W-1:0]  cx, cy, cz);
    write_reg(CFG_SIDE_X, CFG_W'(sx));
    write_reg(CFG_SIDE_Y, CFG_W'(sy));
    write_reg(CFG_SIDE_Z, CFG_W'(sz));
    write_reg(CFG_COUNT_X, CFG_W'(cx));
    write_reg(CFG_COUNT_Y, CFG_W'(cy));
    write_reg(CFG_COUNT_Z, CFG_W'(cz));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  function automatic logic [SIDE_W-1:0] pick_side();
    case ($urandom_range(0, 3))
      0:       return SIDE_W'($urandom_range(1, 16));
      1:       return SIDE_W'($urandom_range(17, 4096));
      2:       return SIDE_W'($urandom_range(1, SIDE_MAX));
      default: return SIDE_W'($urandom_range(256, 65536));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 3))
      0:       return CNT_W'($urandom_range(1, 8));
      1:       return CNT_W'($urandom_range(0, CNT_MAX));
      2:       return CNT_W'(COORD_MAX + 1);
      default: return CNT_W'($urandom_range(1, COORD_MAX + 1));
    endcase
  endfunction

  // Position whose cell coordinate is mostly in range, biased to the edges
  function automatic logic [FIELD_W-1:0] aim_position(input int axis);
    longint unsigned s, q, v;
    s = (side_cfg[axis] == 0) ? 1 : side_cfg[axis];
    case ($urandom_range(0, 4))
      0:       q = 0;
      1:       q = COORD_MAX;
      2:       q = (count_cfg[axis] == 0) ? COORD_MAX : count_cfg[axis] - 1;
      default: q = $urandom_range(0, COORD_MAX);
    endcase
    v = q * s + $urandom_range(0, s - 1);
    if (v > POS_MAX) v = $urandom_range(0, POS_MAX);
    return v[FIELD_W-1:0];
  endfunction

  task automatic send_random_position;
    if ($urandom_range(0, 4) == 0)
      send_position(FIELD_W'($urandom_range(0, POS_MAX)),
                    FIELD_W'($urandom_range(0, POS_MAX)),
                    FIELD_W'($urandom_range(0, POS_MAX)));
    else
      send_position(aim_position(0), aim_position(1), aim_position(2));
  endtask

  task automatic test_reset_defaults;
    send_position('0, '0, '0);
    send_position(FIELD_W'(16'hFFFF), FIELD_W'(16'hFFFF), FIELD_W'(16'hFFFF));
    send_position(FIELD_W'(32'h10000), '0, '0);
    send_position('0, FIELD_W'(32'h10000), '0);
    send_position('0, '0, POS_MAX);
    send_position(POS_MAX, POS_MAX, POS_MAX);
    send_position(FIELD_W'(24'h00AB12), FIELD_W'(24'h005501), FIELD_W'(24'h00FF00));
    drain();
  endtask

  task automatic test_register_extremes;
    // unit sides, single-cell wrap, coordinates beyond the count
    load_config(SIDE_W'(1), SIDE_W'(1), SIDE_W'(1), CNT_W'(1), CNT_W'(1), CNT_W'(1));
    send_position('0, '0, '0);
    send_position(FIELD_W'(5), FIELD_W'(200), FIELD_W'(COORD_MAX));
    send_position(FIELD_W'(COORD_MAX + 1), '0, '0);
    drain();
    // zero count wraps as the full coordinate range
    load_config(SIDE_W'(1), SIDE_W'(1), SIDE_W'(1), '0, '0, '0);
    send_position('0, FIELD_W'(128), FIELD_W'(COORD_MAX));
    drain();
    // counts above the coordinate range get masked when packed
    load_config(SIDE_W'(1), SIDE_W'(1), SIDE_W'(1), CNT_MAX, CNT_W'(300),
                CNT_W'(COORD_MAX + 2));
    send_position(FIELD_W'(COORD_MAX), FIELD_W'(COORD_MAX), '0);
    send_position('0, '0, FIELD_W'(COORD_MAX));
    drain();
    load_config(SIDE_MAX, SIDE_MAX, SIDE_MAX, CNT_W'(3), CNT_W'(2), CNT_W'(3));
    send_position(POS_MAX, FIELD_W'(POS_MAX - 1), '0);
    send_position('0, POS_MAX, POS_MAX);
    drain();
    // zero side flags the item on whichever axis has it
    load_config('0, SIDE_W'(256), SIDE_W'(256), CNT_W'(4), CNT_W'(4), CNT_W'(4));
    send_position('0, '0, '0);
    drain();
    load_config(SIDE_W'(256), '0, SIDE_W'(256), CNT_W'(4), CNT_W'(4), CNT_W'(4));
    send_position(FIELD_W'(512), '0, FIELD_W'(512));
    drain();
    load_config(SIDE_W'(256), SIDE_W'(256), '0, CNT_W'(4), CNT_W'(4), CNT_W'(4));
    send_position(FIELD_W'(768), FIELD_W'(1024), '0);
    send_position(FIELD_W'(768), FIELD_W'(1024), POS_MAX);
    drain();
  endtask

  task automatic test_random_settings;
    for (int phase = 0; phase < 4; phase++) begin
      load_config(pick_side(), pick_side(), pick_side(),
                  pick_count(), pick_count(), pick_count());
      repeat (20) send_random_position();
      drain();
    end
  endtask

  // Hold the result side off so the pipeline backs up into the input
  task automatic test_backpressure;
    src_gaps  = 1'b0;
    hold_req  = HOLD_LONG;
    repeat (20) send_random_position();
    drain();
    src_gaps  = 1'b1;
  endtask

  task automatic test_full_rate;
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    load_config(SIDE_W'($urandom_range(1, 64)), SIDE_W'($urandom_range(1, 64)),
                SIDE_W'($urandom_range(1, 64)), pick_count(), pick_count(), pick_count());
    repeat (15) send_random_position();
    drain();
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    src_gaps   = 1'b1;
    sink_gaps  = 1'b1;
    hold_req   = 0;
    for (int a = 0; a < DIM; a++) begin
      side_cfg[a]  = SIDE_RESET;
      count_cfg[a] = CNT_RESET;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_random_settings();
    test_backpressure();
    test_full_rate();

    if (neighbor_q.size() != 0) errors += neighbor_q.size();
    $display("Sent %0d positions (%0d out of range) over %0d register settings;",
             positions_sent, flagged_sent, settings_used);
    $display("checked %0d neighbor results, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/pcne_pkg.sv
rtl/core/pcne_cellpipe.sv
rtl/core/pcne_enum.sv
rtl/core/periodic_cell_neighbor_enumerator.sv
test/periodic_cell_neighbor_enumerator_tb.sv
